// ===== design/cei_pkg.sv =====
// ----------------------------------------------------------------------------
// cei_pkg
// Shared types and constants of the cusp equivalence index table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cei_pkg;

  localparam int LIST_CAPACITY_DEF = 256;

  localparam int NUM_W     = 32;
  localparam int DEN_W     = 31;
  localparam int LEVEL_W   = 31;
  localparam int IDX_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 31;
  localparam int MODE_W    = 2;

  // signed numerator with room for negation, and Bezout coefficient width
  localparam int SNUM_W = NUM_W + 1;
  localparam int COEF_W = NUM_W + 2;

  localparam int ARITH_W = 64;
  localparam int ACNT_W  = $clog2(ARITH_W);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLUS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MINUS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SELF  = 2'd2;

  localparam logic OP_DIV = 1'b0;
  localparam logic OP_MUL = 1'b1;

  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [MODE_W-1:0] mode;
    logic              plus;
  } item_t;

  typedef struct packed {
    logic               start;
    logic               op;
    logic [ARITH_W-1:0] a;
    logic [ARITH_W-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic               done;
    logic [ARITH_W-1:0] quo;
    logic [ARITH_W-1:0] rem;
    logic [ARITH_W-1:0] prod;
  } arith_rsp_t;

endpackage

`default_nettype wire

// ===== design/cei_ram.sv =====
// ----------------------------------------------------------------------------
// cei_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cei_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                           clk,
  input  wire logic                                           we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]                               wdata,
  input  wire logic                                           re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic      [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/cei_arith.sv =====
// ----------------------------------------------------------------------------
// cei_arith
// Shared bit-serial 64-bit unit: unsigned divide with remainder, or
// multiply keeping the low 64 bits. One bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cei_arith (
  input  wire logic                clk,
  input  wire logic                rst,
  input  cei_pkg::arith_req_t      req,
  output cei_pkg::arith_rsp_t      rsp
);

  localparam int W = cei_pkg::ARITH_W;

  logic                       busy;
  logic                       done;
  logic                       op;
  logic [cei_pkg::ACNT_W-1:0] cnt;
  logic [W-1:0]               acc;
  logic [W-1:0]               ma;
  logic [W-1:0]               mb;
  logic [W-1:0]               rem_r;
  logic [W-1:0]               quo_r;
  logic [W-1:0]               dv;

  logic [W:0] rem_sh;
  logic [W:0] diff;
  logic       ge;

  assign rem_sh = {rem_r, quo_r[W-1]};
  assign diff   = rem_sh - {1'b0, dv};
  assign ge     = rem_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        done <= 1'b0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == cei_pkg::ACNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op    <= req.op;
      acc   <= '0;
      ma    <= req.a;
      mb    <= req.b;
      rem_r <= '0;
      quo_r <= req.a;
      dv    <= req.b;
    end else if (busy) begin
      if (op == cei_pkg::OP_MUL) begin
        acc <= acc + (mb[0] ? ma : '0);
        ma  <= {ma[W-2:0], 1'b0};
        mb  <= {1'b0, mb[W-1:1]};
      end else begin
        rem_r <= ge ? diff[W-1:0] : rem_sh[W-1:0];
        quo_r <= {quo_r[W-2:0], ge};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;
  assign rsp.prod = acc;

endmodule

`default_nettype wire

// ===== design/cei_front.sv =====
// ----------------------------------------------------------------------------
// cei_front
// Input side: accepts cusps, tags each with its indexing mode and plus flag,
// and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cei_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [cei_pkg::NUM_W-1:0]     cusp_num,
  input  wire logic [cei_pkg::DEN_W-1:0]     cusp_den,
  input  wire logic                          plus_mode,
  input  wire logic [cei_pkg::MODE_W-1:0]    index_mode,
  output cei_pkg::item_t                     head,
  output logic                               head_valid,
  input  wire logic                          head_pop
);

  localparam int DEPTH = cei_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cei_pkg::item_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;

  cei_pkg::item_t         item_in;
  logic [cei_pkg::MODE_W-1:0] mode_n;
  logic                   do_push;
  logic                   do_pop;

  always_comb begin
    if (index_mode == cei_pkg::MODE_MINUS || index_mode == cei_pkg::MODE_SELF) begin
      mode_n = index_mode;
    end else begin
      mode_n = cei_pkg::MODE_PLAIN;
    end
    item_in.num  = cusp_num;
    item_in.den  = cusp_den;
    item_in.mode = mode_n;
    item_in.plus = (mode_n == cei_pkg::MODE_PLAIN) && plus_mode;
  end

  assign full       = (cnt == CNT_W'(DEPTH));
  assign head_valid = (cnt != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/cei_back.sv =====
// ----------------------------------------------------------------------------
// cei_back
// Back end: scans the class list, runs the Gamma_0(N) equivalence test on
// the shared serial unit, appends new classes and holds the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cei_back #(
  parameter int LIST_CAPACITY = cei_pkg::LIST_CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  cei_pkg::item_t                     item,
  input  wire logic                          item_valid,
  output logic                               item_pop,
  input  wire logic [cei_pkg::LEVEL_W-1:0]   level,
  output logic                               out_valid,
  output logic [cei_pkg::IDX_W-1:0]          out_index,
  output logic                               out_full,
  input  wire logic                          out_pop
);

  localparam int W     = cei_pkg::ARITH_W;
  localparam int NW    = cei_pkg::NUM_W;
  localparam int DW    = cei_pkg::DEN_W;
  localparam int PW    = cei_pkg::SNUM_W;
  localparam int SW    = cei_pkg::COEF_W;
  localparam int IW    = cei_pkg::IDX_W;
  localparam int CW    = $clog2(LIST_CAPACITY + 1);
  localparam int AW    = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int EW    = CW + IW;
  localparam int RAM_W = NW + DW;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_SCAN     = 5'd1;
  localparam logic [4:0] S_READ     = 5'd2;
  localparam logic [4:0] S_APPEND   = 5'd3;
  localparam logic [4:0] S_DONE     = 5'd4;
  localparam logic [4:0] S_EQ_START = 5'd5;
  localparam logic [4:0] S_EQ_END   = 5'd6;
  localparam logic [4:0] S_GCD      = 5'd7;
  localparam logic [4:0] S_GCD_WAIT = 5'd8;
  localparam logic [4:0] S_GCD_RET  = 5'd9;
  localparam logic [4:0] S_BEZ_LOOP = 5'd10;
  localparam logic [4:0] S_BEZ_DIV  = 5'd11;
  localparam logic [4:0] S_BEZ_MUL  = 5'd12;
  localparam logic [4:0] S_QQ_MUL   = 5'd13;
  localparam logic [4:0] S_Z_U      = 5'd14;
  localparam logic [4:0] S_Z_V      = 5'd15;
  localparam logic [4:0] S_MA       = 5'd16;
  localparam logic [4:0] S_MB       = 5'd17;
  localparam logic [4:0] S_MC       = 5'd18;
  localparam logic [4:0] S_MD       = 5'd19;
  localparam logic [4:0] S_SUM      = 5'd20;

  localparam logic [1:0] R_SELF   = 2'd0;
  localparam logic [1:0] R_FIRST  = 2'd1;
  localparam logic [1:0] R_SECOND = 2'd2;

  localparam logic [1:0] G_A = 2'd0;
  localparam logic [1:0] G_B = 2'd1;
  localparam logic [1:0] G_C = 2'd2;

  localparam logic B_1 = 1'b0;
  localparam logic B_2 = 1'b1;

  function automatic logic [W-1:0] abs_coef(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] m;
    m = (x < 0) ? -x : x;
    return W'(unsigned'(m));
  endfunction

  function automatic logic [NW-1:0] abs_num(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] m;
    m = (x < 0) ? -x : x;
    return m[NW-1:0];
  endfunction

  logic [4:0] state;
  logic [1:0] eq_ret;
  logic [1:0] gret;
  logic       bret;
  logic       side;
  logic       eq;

  logic [cei_pkg::MODE_W-1:0] mode;
  logic                       plus;
  logic                       tplus;
  logic [NW-1:0]              p;
  logic [DW-1:0]              q;
  logic signed [PW-1:0]       p1;
  logic signed [PW-1:0]       p2;
  logic [DW-1:0]              q1;
  logic [DW-1:0]              q2;

  logic [W-1:0]  ga;
  logic [W-1:0]  gb;
  logic [W-1:0]  g;
  logic [DW-1:0] n1;

  logic [NW-1:0]        ba;
  logic [DW-1:0]        bb;
  logic                 bneg;
  logic signed [SW-1:0] x0;
  logic signed [SW-1:0] x1;
  logic signed [SW-1:0] s1;
  logic signed [SW-1:0] s2;
  logic signed [SW-1:0] sres;
  logic signed [SW-1:0] s_side;
  logic [W-1:0]         xn_wide;

  logic [W-1:0] ms;
  logic [W-1:0] u;
  logic [W-1:0] r_pos;

  logic [CW-1:0] i;
  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic          full_r;

  logic [EW-1:0] i_ext;
  logic [EW-1:0] c_ext;
  logic [IW-1:0] i_pos;
  logic [IW-1:0] c_pos;

  cei_pkg::arith_req_t ar;
  cei_pkg::arith_rsp_t rsp;

  logic              ram_we;
  logic              ram_re;
  logic [RAM_W-1:0]  ram_rdata;
  logic              room;

  cei_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (ar),
    .rsp (rsp)
  );

  cei_ram #(
    .WIDTH (RAM_W),
    .DEPTH (LIST_CAPACITY)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({p, q}),
    .re    (ram_re),
    .raddr (i[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign room     = (count < CW'(LIST_CAPACITY));
  assign ram_we   = (state == S_APPEND) && room;
  assign ram_re   = (state == S_SCAN) && (i != count);
  assign item_pop = (state == S_IDLE) && item_valid;

  assign i_ext   = EW'(i) + EW'(1);
  assign c_ext   = EW'(count) + EW'(1);
  assign i_pos   = i_ext[IW-1:0];
  assign c_pos   = c_ext[IW-1:0];

  assign sres    = bneg ? -x0 : x0;
  assign s_side  = side ? s2 : s1;
  assign xn_wide = W'(x0) - rsp.prod;
  assign r_pos   = ((s_side < 0) && (rsp.rem != '0)) ? g - rsp.rem : rsp.rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      ar.start  <= 1'b0;
    end else begin
      if (ar.start) begin
        ar.start <= 1'b0;
      end
      if (out_pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            p      <= item.num;
            q      <= item.den;
            mode   <= item.mode;
            plus   <= item.plus;
            full_r <= 1'b0;
            idx    <= '0;
            i      <= '0;
            if (item.mode == cei_pkg::MODE_MINUS || item.mode == cei_pkg::MODE_SELF) begin
              p1     <= PW'($signed(item.num));
              p2     <= -PW'($signed(item.num));
              q1     <= item.den;
              q2     <= item.den;
              tplus  <= 1'b0;
              eq_ret <= R_SELF;
              state  <= S_EQ_START;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          state <= (i == count) ? S_APPEND : S_READ;
        end
        S_READ: begin
          p1     <= PW'($signed(p));
          q1     <= q;
          p2     <= PW'($signed(ram_rdata[RAM_W-1:DW]));
          q2     <= ram_rdata[DW-1:0];
          tplus  <= plus;
          eq_ret <= R_FIRST;
          state  <= S_EQ_START;
        end
        S_APPEND: begin
          if (room) begin
            count <= count + 1'b1;
            idx   <= c_pos;
          end else begin
            full_r <= 1'b1;
            idx    <= '0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_index <= idx;
            out_full  <= full_r;
            state     <= S_IDLE;
          end
        end
        S_EQ_START: begin
          if (p1 == p2 && q1 == q2) begin
            eq    <= 1'b1;
            state <= S_EQ_END;
          end else begin
            ga    <= W'(level);
            gb    <= W'(q1);
            gret  <= G_A;
            state <= S_GCD;
          end
        end
        S_EQ_END: begin
          case (eq_ret)
            R_SELF: begin
              if ((mode == cei_pkg::MODE_MINUS && eq) ||
                  (mode == cei_pkg::MODE_SELF && !eq)) begin
                idx   <= '0;
                state <= S_DONE;
              end else begin
                i     <= '0;
                state <= S_SCAN;
              end
            end
            R_FIRST: begin
              if (eq) begin
                idx   <= i_pos;
                state <= S_DONE;
              end else if (mode == cei_pkg::MODE_MINUS) begin
                p1     <= -PW'($signed(p));
                q1     <= q;
                tplus  <= 1'b0;
                eq_ret <= R_SECOND;
                state  <= S_EQ_START;
              end else begin
                i     <= i + 1'b1;
                state <= S_SCAN;
              end
            end
            R_SECOND: begin
              if (eq) begin
                idx   <= -i_pos;
                state <= S_DONE;
              end else begin
                i     <= i + 1'b1;
                state <= S_SCAN;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_GCD: begin
          if (gb == '0) begin
            state <= S_GCD_RET;
          end else begin
            ar.start <= 1'b1;
            ar.op    <= cei_pkg::OP_DIV;
            ar.a     <= ga;
            ar.b     <= gb;
            state    <= S_GCD_WAIT;
          end
        end
        S_GCD_WAIT: begin
          if (rsp.done) begin
            ga    <= gb;
            gb    <= rsp.rem;
            state <= S_GCD;
          end
        end
        S_GCD_RET: begin
          case (gret)
            G_A: begin
              n1    <= ga[DW-1:0];
              ga    <= W'(level);
              gb    <= W'(q2);
              gret  <= G_B;
              state <= S_GCD;
            end
            G_B: begin
              if (ga != W'(n1)) begin
                eq    <= 1'b0;
                state <= S_EQ_END;
              end else begin
                ba    <= abs_num(p1);
                bb    <= q1;
                bneg  <= (p1 < 0);
                x0    <= SW'(1);
                x1    <= '0;
                bret  <= B_1;
                state <= S_BEZ_LOOP;
              end
            end
            G_C: begin
              g        <= ga;
              ar.start <= 1'b1;
              if (ga == '0) begin
                ar.op <= cei_pkg::OP_MUL;
                ar.a  <= W'(s1);
                ar.b  <= W'(q2);
                state <= S_Z_U;
              end else begin
                ar.op <= cei_pkg::OP_DIV;
                ar.a  <= abs_coef(s1);
                ar.b  <= ga;
                side  <= 1'b0;
                state <= S_MA;
              end
            end
            default: begin
              eq    <= 1'b0;
              state <= S_EQ_END;
            end
          endcase
        end
        S_BEZ_LOOP: begin
          if (bb == '0) begin
            if (bret == B_1) begin
              s1    <= sres;
              ba    <= abs_num(p2);
              bb    <= q2;
              bneg  <= (p2 < 0);
              x0    <= SW'(1);
              x1    <= '0;
              bret  <= B_2;
            end else begin
              s2       <= sres;
              ar.start <= 1'b1;
              ar.op    <= cei_pkg::OP_MUL;
              ar.a     <= W'(q1);
              ar.b     <= W'(q2);
              state    <= S_QQ_MUL;
            end
          end else begin
            ar.start <= 1'b1;
            ar.op    <= cei_pkg::OP_DIV;
            ar.a     <= W'(ba);
            ar.b     <= W'(bb);
            state    <= S_BEZ_DIV;
          end
        end
        S_BEZ_DIV: begin
          if (rsp.done) begin
            ba       <= {1'b0, bb};
            bb       <= rsp.rem[DW-1:0];
            ar.start <= 1'b1;
            ar.op    <= cei_pkg::OP_MUL;
            ar.a     <= rsp.quo;
            ar.b     <= W'(x1);
            state    <= S_BEZ_MUL;
          end
        end
        S_BEZ_MUL: begin
          if (rsp.done) begin
            x0    <= x1;
            x1    <= signed'(xn_wide[SW-1:0]);
            state <= S_BEZ_LOOP;
          end
        end
        S_QQ_MUL: begin
          if (rsp.done) begin
            ga    <= W'(level);
            gb    <= rsp.prod;
            gret  <= G_C;
            state <= S_GCD;
          end
        end
        S_Z_U: begin
          if (rsp.done) begin
            u        <= rsp.prod;
            ar.start <= 1'b1;
            ar.op    <= cei_pkg::OP_MUL;
            ar.a     <= W'(s2);
            ar.b     <= W'(q1);
            state    <= S_Z_V;
          end
        end
        S_Z_V: begin
          if (rsp.done) begin
            eq    <= (u == rsp.prod) || (tplus && ((u + rsp.prod) == '0));
            state <= S_EQ_END;
          end
        end
        S_MA: begin
          if (rsp.done) begin
            ms       <= r_pos;
            ar.start <= 1'b1;
            ar.op    <= cei_pkg::OP_DIV;
            ar.a     <= side ? W'(q1) : W'(q2);
            ar.b     <= g;
            state    <= S_MB;
          end
        end
        S_MB: begin
          if (rsp.done) begin
            ar.start <= 1'b1;
            ar.op    <= cei_pkg::OP_MUL;
            ar.a     <= ms;
            ar.b     <= rsp.rem;
            state    <= S_MC;
          end
        end
        S_MC: begin
          if (rsp.done) begin
            ar.start <= 1'b1;
            ar.op    <= cei_pkg::OP_DIV;
            ar.a     <= rsp.prod;
            ar.b     <= g;
            state    <= S_MD;
          end
        end
        S_MD: begin
          if (rsp.done) begin
            if (!side) begin
              u        <= rsp.rem;
              side     <= 1'b1;
              ar.start <= 1'b1;
              ar.op    <= cei_pkg::OP_DIV;
              ar.a     <= abs_coef(s2);
              ar.b     <= g;
              state    <= S_MA;
            end else if (u == rsp.rem) begin
              eq    <= 1'b1;
              state <= S_EQ_END;
            end else if (!tplus) begin
              eq    <= 1'b0;
              state <= S_EQ_END;
            end else begin
              ar.start <= 1'b1;
              ar.op    <= cei_pkg::OP_DIV;
              ar.a     <= u + rsp.rem;
              ar.b     <= g;
              state    <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (rsp.done) begin
            eq    <= (rsp.rem == '0);
            state <= S_EQ_END;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/cusp_equivalence_index_table_unit.sv =====
// ----------------------------------------------------------------------------
// cusp_equivalence_index_table_unit
// Cusp class table for Gamma_0(N): returns the class index of each cusp.
// ----------------------------------------------------------------------------
// Each cusp p/q pushed in yields one result item: the 1-based index of its
// class in the list (negative in minus-space mode when -c is listed, zero
// when the test against its negation drops the cusp or when a new class
// had no room), with list_full set when a new class had no room. Items are
// handled one at a time; a two-entry input queue and a result register let
// both sides run ahead. Every arithmetic step runs on a single shared
// bit-serial 64-bit divide/multiply unit, so an item costs in proportion to
// the number of operations: each equivalence test needs up to three gcd
// chains against the level, two extended-Euclid chains and a few modular
// products; the chain lengths depend on the sizes of level and the
// denominators. Each stored class scanned takes one test, two in
// minus-space mode, and minus-space and self-conjugate modes add one test
// of the cusp against its negation, so the cost scales with the number of
// classes scanned.
// The list starts empty after reset and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module cusp_equivalence_index_table_unit #(
  parameter int LIST_CAPACITY = cei_pkg::LIST_CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [cei_pkg::NUM_W-1:0]         cusp_num,
  input  wire logic [cei_pkg::DEN_W-1:0]         cusp_den,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [cei_pkg::IDX_W-1:0]              class_index,
  output logic                                   list_full,
  input  wire logic                              cfg_write,
  input  wire logic [cei_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cei_pkg::CFG_W-1:0]         cfg_data
);

  logic [cei_pkg::LEVEL_W-1:0] level;
  logic                        plus_mode;
  logic [cei_pkg::MODE_W-1:0]  index_mode;

  cei_pkg::item_t head;
  logic           head_valid;
  logic           head_pop;
  logic           out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= cei_pkg::LEVEL_W'(1);
      plus_mode  <= 1'b0;
      index_mode <= cei_pkg::MODE_PLAIN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cei_pkg::REG_LEVEL: level      <= cfg_data[cei_pkg::LEVEL_W-1:0];
        cei_pkg::REG_PLUS:  plus_mode  <= cfg_data[0];
        cei_pkg::REG_MODE:  index_mode <= cfg_data[cei_pkg::MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cei_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cusp_num   (cusp_num),
    .cusp_den   (cusp_den),
    .plus_mode  (plus_mode),
    .index_mode (index_mode),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  cei_back #(
    .LIST_CAPACITY (LIST_CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (head),
    .item_valid (head_valid),
    .item_pop   (head_pop),
    .level      (level),
    .out_valid  (out_valid),
    .out_index  (class_index),
    .out_full   (list_full),
    .out_pop    (pop)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire
